>>> rtl/core/contour_endpoint_scanline_crossing_assert.svh
// Assertion macros for the contour endpoint scan line crossing block.
// Used by the port checker; no other dependencies.
`ifndef CONTOUR_ENDPOINT_SCANLINE_CROSSING_ASSERT_SVH
`define CONTOUR_ENDPOINT_SCANLINE_CROSSING_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CESC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cesc port check failed");

// Next-cycle implication, disabled while reset is low.
`define CESC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cesc port check failed");

`endif

>>> rtl/core/cesc_pkg.sv
// Shared types and constants of the contour endpoint scan line crossing block.
// No dependencies.
`default_nettype none

package cesc_pkg;

    // Default parameter values
    localparam int FRAC_BITS_DEF  = 6;
    localparam int COORD_BITS_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;

    // Port field widths
    localparam int PT_W       = 32;
    localparam int SCAN_W     = 26;
    localparam int QUAD_W     = 3;
    localparam int IN_DATA_W  = 2 * PT_W;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = ((2 * SCAN_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2 + QUAD_W;

    localparam int SCAN_MAX = (1 <<< (SCAN_W - 1)) - 1;
    localparam int SCAN_MIN = -(1 <<< (SCAN_W - 1));

    // Configuration port
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 6;
    localparam logic [CFG_AW-1:0] CFG_IDX_DROPOUT  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_IDX_FRACTION = 1'b1;
    localparam logic              CFG_DROPOUT_RST  = 1'b1;
    localparam logic [CFG_DW-1:0] CFG_FRACTION_RST = 6'd32;

    typedef struct packed {
        logic              dropout;
        logic [CFG_DW-1:0] fraction;
    } t_cfg;

    typedef enum logic [IN_USER_W-1:0] {
        OP_BEGIN = 2'd0,
        OP_POINT = 2'd1,
        OP_END   = 2'd2
    } t_op;

    // Event kinds, in emit order; also the bit positions of the event mask
    localparam int EV_N = 4;
    typedef enum logic [1:0] {
        EV_H_ON  = 2'd0,
        EV_H_OFF = 2'd1,
        EV_V_ON  = 2'd2,
        EV_V_OFF = 2'd3
    } t_ev;

    localparam logic [QUAD_W-1:0] Q_H_ON  = 3'd1;
    localparam logic [QUAD_W-1:0] Q_H_OFF = 3'd4;
    localparam logic [QUAD_W-1:0] Q_V_ON  = 3'd2;
    localparam logic [QUAD_W-1:0] Q_V_OFF = 3'd1;

    localparam logic AXIS_H   = 1'b0;
    localparam logic AXIS_V   = 1'b1;
    localparam logic EDGE_ON  = 1'b0;
    localparam logic EDGE_OFF = 1'b1;

endpackage

`default_nettype wire

>>> rtl/core/cesc_front.sv
// Front end: accepts contour points, keeps the contour state and classifies
// each point into a mask of crossing events. Depends on cesc_pkg.
`default_nettype none

module cesc_front #(
    parameter int FRAC_BITS  = cesc_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = cesc_pkg::COORD_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire  cesc_pkg::t_cfg                i_cfg,
    input  wire                                 i_valid,
    output logic                                o_ready,
    input  wire  [cesc_pkg::IN_USER_W-1:0]      i_op,
    input  wire  [cesc_pkg::PT_W-1:0]           i_point_x,
    input  wire  [cesc_pkg::PT_W-1:0]           i_point_y,
    input  wire                                 i_queue_full,
    output logic                                o_push,
    output logic [cesc_pkg::EV_N-1:0]           o_mask,
    output logic [COORD_BITS-1:0]               o_x,
    output logic [COORD_BITS-1:0]               o_y
);

    typedef logic signed [COORD_BITS-1:0] t_coord;

    // Crossing table written for the horizontal case; the vertical case maps
    // onto it by swapping axes and flipping the x sense. Returns {off, on}.
    function automatic logic [1:0] crossing(
        input logic p_gt, input logic p_lt,
        input logic a_gt, input logic a_lt,
        input logic b_gt, input logic b_lt,
        input logic c_gt, input logic c_lt
    );
        logic on_e;
        logic off_e;
        on_e  = 1'b0;
        off_e = 1'b0;
        if (p_gt) begin
            if (a_gt) on_e = 1'b1;
            else if (a_lt) begin
                on_e  = 1'b1;
                off_e = 1'b1;
            end else if (b_lt) on_e = 1'b1;
        end else if (p_lt) begin
            if (a_gt) begin
                on_e  = 1'b1;
                off_e = 1'b1;
            end else if (a_lt) off_e = 1'b1;
            else if (b_gt) off_e = 1'b1;
        end else begin
            if (a_gt) on_e = c_gt;
            else if (a_lt) off_e = c_lt;
            else if (b_gt && c_lt) off_e = 1'b1;
            else if (b_lt && c_gt) on_e = 1'b1;
        end
        return {off_e, on_e};
    endfunction

    t_coord r_older_x, r_older_y, r_recent_x, r_recent_y, r_saved_x, r_saved_y;
    logic   r_start;
    t_coord n_older_x, n_older_y, n_recent_x, n_recent_y, n_saved_x, n_saved_y;
    logic   n_start;

    t_coord                   px, py, nx, ny;
    logic [FRAC_BITS+5:0]     frac_ext;
    logic [FRAC_BITS-1:0]     frac;
    logic                     hon, von, same, run, accept;
    logic [1:0]               h_ev, v_ev;
    cesc_pkg::t_op            op;

    assign px       = $signed(i_point_x[COORD_BITS-1:0]);
    assign py       = $signed(i_point_y[COORD_BITS-1:0]);
    assign op       = cesc_pkg::t_op'(i_op);
    assign frac_ext = {{FRAC_BITS{1'b0}}, i_cfg.fraction};
    assign frac     = frac_ext[FRAC_BITS-1:0];

    assign hon  = (r_recent_y[FRAC_BITS-1:0] == frac);
    assign von  = i_cfg.dropout && (r_recent_x[FRAC_BITS-1:0] == frac);
    assign same = (hon || von) && (px == r_recent_x) && (py == r_recent_y);

    // End of contour closes against the point that followed the start
    assign nx = (op == cesc_pkg::OP_END) ? r_saved_x : px;
    assign ny = (op == cesc_pkg::OP_END) ? r_saved_y : py;

    assign h_ev = crossing(ny > r_recent_y, ny < r_recent_y,
                           r_recent_y > r_older_y, r_recent_y < r_older_y,
                           r_recent_x > r_older_x, r_recent_x < r_older_x,
                           nx > r_recent_x, nx < r_recent_x);
    assign v_ev = crossing(nx < r_recent_x, nx > r_recent_x,
                           r_recent_x < r_older_x, r_recent_x > r_older_x,
                           r_recent_y > r_older_y, r_recent_y < r_older_y,
                           ny > r_recent_y, ny < r_recent_y);

    assign run = !r_start &&
                 (((op == cesc_pkg::OP_POINT) && !same) || (op == cesc_pkg::OP_END));

    always_comb begin
        o_mask = '0;
        if (run) begin
            o_mask[cesc_pkg::EV_H_ON]  = h_ev[0] & hon;
            o_mask[cesc_pkg::EV_H_OFF] = h_ev[1] & hon;
            o_mask[cesc_pkg::EV_V_ON]  = v_ev[0] & von;
            o_mask[cesc_pkg::EV_V_OFF] = v_ev[1] & von;
        end
    end

    assign o_ready = !i_queue_full;
    assign accept  = i_valid && o_ready;
    assign o_push  = accept && (o_mask != '0);
    assign o_x     = r_recent_x;
    assign o_y     = r_recent_y;

    always_comb begin
        n_older_x  = r_older_x;
        n_older_y  = r_older_y;
        n_recent_x = r_recent_x;
        n_recent_y = r_recent_y;
        n_saved_x  = r_saved_x;
        n_saved_y  = r_saved_y;
        n_start    = r_start;
        if (accept) begin
            unique case (op)
                cesc_pkg::OP_BEGIN: begin
                    n_recent_x = px;
                    n_recent_y = py;
                    n_start    = 1'b1;
                end
                cesc_pkg::OP_POINT: begin
                    if (!same) begin
                        if (r_start && (hon || von)) begin
                            n_saved_x = px;
                            n_saved_y = py;
                        end
                        n_older_x  = r_recent_x;
                        n_older_y  = r_recent_y;
                        n_recent_x = px;
                        n_recent_y = py;
                        n_start    = 1'b0;
                    end
                end
                default: begin
                    // end of contour and unused codes leave the state alone
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older_x  <= '0;
            r_older_y  <= '0;
            r_recent_x <= '0;
            r_recent_y <= '0;
            r_saved_x  <= '0;
            r_saved_y  <= '0;
            r_start    <= 1'b1;
        end else begin
            r_older_x  <= n_older_x;
            r_older_y  <= n_older_y;
            r_recent_x <= n_recent_x;
            r_recent_y <= n_recent_y;
            r_saved_x  <= n_saved_x;
            r_saved_y  <= n_saved_y;
            r_start    <= n_start;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/cesc_fifo.sv
// Short job queue between the front end and the back end.
// Depends on cesc_pkg only through the parameters handed down.
`default_nettype none

module cesc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire  [WIDTH-1:0] i_data,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/cesc_back.sv
// Back end: walks the event mask of each queued job, rounds the scan
// coordinates and drives the registered output stream. Depends on cesc_pkg.
`default_nettype none

module cesc_back #(
    parameter int FRAC_BITS  = cesc_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = cesc_pkg::COORD_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_empty,
    input  wire  [cesc_pkg::EV_N-1:0]            i_mask,
    input  wire  [COORD_BITS-1:0]                i_x,
    input  wire  [COORD_BITS-1:0]                i_y,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [cesc_pkg::OUT_DATA_W-1:0]      o_data,
    output logic [cesc_pkg::OUT_USER_W-1:0]      o_user,
    output logic                                 o_last
);

    localparam int SUM_W = COORD_BITS + 1;
    localparam int EXT_W = (SUM_W > cesc_pkg::SCAN_W) ? SUM_W : cesc_pkg::SCAN_W;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic signed [EXT_W-1:0]      t_ext;

    localparam int   HALF_I  = 1 << (FRAC_BITS - 1);
    localparam t_sum HALF    = t_sum'(HALF_I);
    localparam t_sum HALF_M1 = t_sum'(HALF_I - 1);
    localparam t_ext SAT_HI  = t_ext'(cesc_pkg::SCAN_MAX);
    localparam t_ext SAT_LO  = t_ext'(cesc_pkg::SCAN_MIN);

    // Floor of (v + a) / 2^FRAC_BITS at full precision, clamped to scan range
    function automatic logic [cesc_pkg::SCAN_W-1:0] round_sat(input t_coord v, input t_sum a);
        t_sum s;
        t_sum sh;
        t_ext e;
        s  = t_sum'(v) + a;
        sh = s >>> FRAC_BITS;
        e  = t_ext'(sh);
        if (e > SAT_HI) e = SAT_HI;
        else if (e < SAT_LO) e = SAT_LO;
        return e[cesc_pkg::SCAN_W-1:0];
    endfunction

    logic [cesc_pkg::EV_N-1:0]   r_mask;
    t_coord                      r_x, r_y;
    logic                        r_valid;
    logic [cesc_pkg::SCAN_W-1:0] r_scan_x, r_scan_y;
    logic [cesc_pkg::QUAD_W-1:0] r_quad;
    logic                        r_axis, r_edge, r_last;

    cesc_pkg::t_ev               ev;
    logic [cesc_pkg::EV_N-1:0]   pick, rest;
    logic                        have, adv, load;
    logic                        axis, edge_off;
    logic [cesc_pkg::QUAD_W-1:0] quad;
    t_sum                        add, add_x, add_y;

    // Lowest pending event bit first: horizontal before vertical, on before off
    always_comb begin
        if (r_mask[cesc_pkg::EV_H_ON])       ev = cesc_pkg::EV_H_ON;
        else if (r_mask[cesc_pkg::EV_H_OFF]) ev = cesc_pkg::EV_H_OFF;
        else if (r_mask[cesc_pkg::EV_V_ON])  ev = cesc_pkg::EV_V_ON;
        else                                 ev = cesc_pkg::EV_V_OFF;
    end

    always_comb begin
        unique case (ev)
            cesc_pkg::EV_H_ON:  begin
                axis = cesc_pkg::AXIS_H; edge_off = cesc_pkg::EDGE_ON;  quad = cesc_pkg::Q_H_ON;
            end
            cesc_pkg::EV_H_OFF: begin
                axis = cesc_pkg::AXIS_H; edge_off = cesc_pkg::EDGE_OFF; quad = cesc_pkg::Q_H_OFF;
            end
            cesc_pkg::EV_V_ON:  begin
                axis = cesc_pkg::AXIS_V; edge_off = cesc_pkg::EDGE_ON;  quad = cesc_pkg::Q_V_ON;
            end
            default:            begin
                axis = cesc_pkg::AXIS_V; edge_off = cesc_pkg::EDGE_OFF; quad = cesc_pkg::Q_V_OFF;
            end
        endcase
    end

    assign pick  = cesc_pkg::EV_N'(1) << ev;
    assign rest  = r_mask & ~pick;
    assign have  = (r_mask != '0);
    assign adv   = !r_valid || i_ready;
    assign load  = !have || (adv && (rest == '0));
    assign o_pop = load && !i_empty;

    // Round along the crossing axis, floor across it
    assign add   = (edge_off == cesc_pkg::EDGE_OFF) ? HALF : HALF_M1;
    assign add_x = (axis == cesc_pkg::AXIS_H) ? add : '0;
    assign add_y = (axis == cesc_pkg::AXIS_V) ? add : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) r_mask <= i_empty ? '0 : i_mask;
            else if (adv) r_mask <= rest;
            if (adv) r_valid <= have;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_empty) begin
            r_x <= $signed(i_x);
            r_y <= $signed(i_y);
        end
        if (adv && have) begin
            r_scan_x <= round_sat(r_x, add_x);
            r_scan_y <= round_sat(r_y, add_y);
            r_quad   <= quad;
            r_axis   <= axis;
            r_edge   <= edge_off;
            r_last   <= (rest == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = {{(cesc_pkg::OUT_DATA_W - 2 * cesc_pkg::SCAN_W){1'b0}}, r_scan_y, r_scan_x};
    assign o_user  = {r_quad, r_edge, r_axis};
    assign o_last  = r_last;

endmodule

`default_nettype wire

>>> rtl/core/contour_endpoint_scanline_crossing.sv
// Top level of the contour endpoint scan line crossing block: configuration
// registers, front end, job queue and back end. Depends on cesc_pkg.
//
// Usage:
//   Slave stream: one contour point per transfer; tuser carries the operation
//   (begin, point, end), tdata the x and y coordinates in signed fixed point.
//   Master stream: one crossing event per transfer; tuser carries axis, edge
//   and quadrant, tdata the rounded scan x and y, tlast marks the final event
//   caused by one input point. Points that cause no event produce nothing.
//   Each event passes the job queue, the back end job register and the output
//   register. Throughput: a point can be taken every cycle while the job
//   queue has room; the back end drains one event per cycle while the
//   receiver is ready, and a point causes zero to four events.
//   When the receiver stalls, the output register holds its event, the back
//   end holds its job and the queue fills; tready falls only when the queue
//   is full. Reset clears the queue, the output valid and the contour state,
//   and loads dropout control on with scan line fraction one half.
//   Configuration writes take effect at the next edge; write them while idle.
`default_nettype none

module contour_endpoint_scanline_crossing #(
    parameter int FRAC_BITS  = cesc_pkg::FRAC_BITS_DEF,
    parameter int COORD_BITS = cesc_pkg::COORD_BITS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // slave stream
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    input  wire  [cesc_pkg::IN_DATA_W-1:0]      i_s_tdata,   // point_x, point_y
    input  wire  [cesc_pkg::IN_USER_W-1:0]      i_s_tuser,   // operation
    // master stream
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    output logic [cesc_pkg::OUT_DATA_W-1:0]     o_m_tdata,   // scan_x, scan_y, zero pad
    output logic [cesc_pkg::OUT_USER_W-1:0]     o_m_tuser,   // axis, edge_res, quadrant
    output logic                                o_m_tlast,
    // configuration writes
    input  wire                                 i_cfg_we,
    input  wire  [cesc_pkg::CFG_AW-1:0]         i_cfg_addr,
    input  wire  [cesc_pkg::CFG_DW-1:0]         i_cfg_wdata
);

    localparam int JOB_W = cesc_pkg::EV_N + 2 * COORD_BITS;

    cesc_pkg::t_cfg              r_cfg;

    logic                        push, pop, q_empty, q_full;
    logic [cesc_pkg::EV_N-1:0]   f_mask, b_mask;
    logic [COORD_BITS-1:0]       f_x, f_y, b_x, b_y;
    logic [JOB_W-1:0]            q_wdata, q_rdata;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dropout  <= cesc_pkg::CFG_DROPOUT_RST;
            r_cfg.fraction <= cesc_pkg::CFG_FRACTION_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                cesc_pkg::CFG_IDX_DROPOUT:  r_cfg.dropout  <= i_cfg_wdata[0];
                cesc_pkg::CFG_IDX_FRACTION: r_cfg.fraction <= i_cfg_wdata;
                default:                    r_cfg          <= r_cfg;
            endcase
        end
    end

    // Classify each point against the contour state
    cesc_front #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_op         (i_s_tuser),
        .i_point_x    (i_s_tdata[cesc_pkg::PT_W-1:0]),
        .i_point_y    (i_s_tdata[cesc_pkg::IN_DATA_W-1:cesc_pkg::PT_W]),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_mask       (f_mask),
        .o_x          (f_x),
        .o_y          (f_y)
    );

    // Queue jobs: event mask plus the point that the events sit on
    assign q_wdata = {f_mask, f_x, f_y};

    cesc_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (cesc_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .i_pop   (pop),
        .o_data  (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign b_mask = q_rdata[JOB_W-1 -: cesc_pkg::EV_N];
    assign b_x    = q_rdata[2*COORD_BITS-1 -: COORD_BITS];
    assign b_y    = q_rdata[COORD_BITS-1:0];

    // Emit the events of each job one transfer at a time
    cesc_back #(
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (q_empty),
        .i_mask  (b_mask),
        .i_x     (b_x),
        .i_y     (b_y),
        .o_pop   (pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_user  (o_m_tuser),
        .o_last  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/core/cesc_chk.sv
// Port checker for the contour endpoint scan line crossing block, bound to
// the top level. Depends on cesc_pkg and the assertion macro header.
`default_nettype none
`include "contour_endpoint_scanline_crossing_assert.svh"

module cesc_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              o_m_tvalid,
    input wire                              i_m_tready,
    input wire [cesc_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    input wire [cesc_pkg::OUT_USER_W-1:0]   o_m_tuser,
    input wire                              o_m_tlast
);

    localparam logic [cesc_pkg::OUT_USER_W-1:0] U_H_ON  =
        {cesc_pkg::Q_H_ON,  cesc_pkg::EDGE_ON,  cesc_pkg::AXIS_H};
    localparam logic [cesc_pkg::OUT_USER_W-1:0] U_H_OFF =
        {cesc_pkg::Q_H_OFF, cesc_pkg::EDGE_OFF, cesc_pkg::AXIS_H};
    localparam logic [cesc_pkg::OUT_USER_W-1:0] U_V_ON  =
        {cesc_pkg::Q_V_ON,  cesc_pkg::EDGE_ON,  cesc_pkg::AXIS_V};
    localparam logic [cesc_pkg::OUT_USER_W-1:0] U_V_OFF =
        {cesc_pkg::Q_V_OFF, cesc_pkg::EDGE_OFF, cesc_pkg::AXIS_V};

    logic                                                   stall, code_ok, is_voff, mid_run;
    logic [cesc_pkg::OUT_DATA_W+cesc_pkg::OUT_USER_W:0]     out_bits;

    assign stall    = o_m_tvalid && !i_m_tready;
    assign out_bits = {o_m_tdata, o_m_tuser, o_m_tlast};
    assign code_ok  = (o_m_tuser == U_H_ON) || (o_m_tuser == U_H_OFF) ||
                      (o_m_tuser == U_V_ON) || (o_m_tuser == U_V_OFF);
    assign is_voff  = o_m_tvalid && (o_m_tuser == U_V_OFF);
    assign mid_run  = o_m_tvalid && i_m_tready && !o_m_tlast;

    // hold a stalled event
    `CESC_ASSERT_NXT(a_hold, i_clk, i_rst_n, stall, o_m_tvalid && $stable(out_bits))

    // quadrant always agrees with axis and edge
    `CESC_ASSERT_IMP(a_code, i_clk, i_rst_n, o_m_tvalid, code_ok)

    // a vertical off event is the final one of its point
    `CESC_ASSERT_IMP(a_voff_last, i_clk, i_rst_n, is_voff, o_m_tlast)

    // events of one point leave without a gap
    `CESC_ASSERT_NXT(a_no_gap, i_clk, i_rst_n, mid_run, o_m_tvalid)

endmodule

bind contour_endpoint_scanline_crossing cesc_chk u_cesc_chk (.*);

`default_nettype wire
